>>> src/calendar_clock_second_adder_top_assert.svh
// Assertion macros shared by the calendar clock RTL.
`ifndef CALENDAR_CLOCK_SECOND_ADDER_TOP_ASSERT_SVH
`define CALENDAR_CLOCK_SECOND_ADDER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CCSA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CCSA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ccsa_pkg.sv
// Shared types and constants of the calendar clock.
`default_nettype none

package ccsa_pkg;

   // Operation codes carried in tuser
   localparam logic [1:0] FUNC_ADD  = 2'd0;
   localparam logic [1:0] FUNC_TIME = 2'd1;
   localparam logic [1:0] FUNC_DATE = 2'd2;

   // Channel widths
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;

   // Shared divider widths
   localparam int DIV_W = 32;
   localparam int REM_W = 7;

   // Divisors of the carry chain and of the leap-year split
   localparam logic [REM_W-1:0] SECS_PER_MIN   = 7'd60;
   localparam logic [REM_W-1:0] HOURS_PER_DAY  = 7'd24;
   localparam logic [REM_W-1:0] YEARS_PER_CENT = 7'd100;

   // Rounded-up reciprocals, exact for any 32-bit dividend
   localparam logic [DIV_W-1:0] RECIP_MIN   = 32'h8888_8889;  // 2^37 / 60
   localparam logic [DIV_W-1:0] RECIP_HOUR  = 32'hAAAA_AAAB;  // 2^36 / 24
   localparam logic [DIV_W-1:0] RECIP_CENT  = 32'h51EB_851F;  // 2^37 / 100
   localparam int               SHIFT_LONG  = 37;
   localparam int               SHIFT_SHORT = 36;

   // Calendar constants
   localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
   localparam logic [13:0] LAST_YEAR       = 14'd9999;
   localparam logic [6:0]  LAST_YEAR_REM   = 7'd99;

   // Sequencer to calendar control
   typedef struct packed {
      logic load;      // take a new date
      logic set_leap;  // take year / 100 split
      logic step;      // advance one day
   } cal_ctl_type;

endpackage

`default_nettype wire

>>> src/calendar_clock_second_adder_top.sv
// Load time or unused code: the result is posted directly. Load date: the year is split by 100
// on the shared divider (taken at once below year 100, else through its product and result stages).
// Add: three carry passes on one shared reciprocal divider (sec/60, min/60, hour/24), each pass
// taken at once when nothing carries, else through the product and result stages; then the carried
// days are stepped one at a time and the result is posted. A new request is taken
// the cycle after its result is posted, even while that result waits. Synchronous reset clears
// to 0001-01-01 00:00:00 with no result pending.
`default_nettype none
`include "calendar_clock_second_adder_top_assert.svh"

module calendar_clock_second_adder_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [30:0] seconds_to_add, [35:31] load_hour, [41:36] load_minute,
   // [47:42] load_second, [61:48] load_year, [65:62] load_month,
   // [70:66] load_day, [71] zero
   input  logic [ccsa_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] func
   input  logic [ccsa_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [13:0] cur_year, [17:14] cur_month, [22:18] cur_day,
   // [27:23] cur_hour, [33:28] cur_minute, [39:34] cur_second
   output logic [ccsa_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import ccsa_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SEC  = 3'd1;
   localparam logic [2:0] S_MIN  = 3'd2;
   localparam logic [2:0] S_HOUR = 3'd3;
   localparam logic [2:0] S_DAYS = 3'd4;
   localparam logic [2:0] S_YEAR = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   // Request fields
   logic [30:0] in_secs;
   logic [4:0]  in_hour;
   logic [5:0]  in_minute;
   logic [5:0]  in_second;
   logic [13:0] in_year;
   logic [3:0]  in_month;
   logic [4:0]  in_day;
   logic [1:0]  in_func;

   logic [2:0]            state_ff, state_in;
   logic [5:0]            sec_ff, sec_in;
   logic [5:0]            min_ff, min_in;
   logic [4:0]            hour_ff, hour_in;
   logic [14:0]           days_ff, days_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  req_fire;
   logic                  slot_free;
   logic                  div_start;
   logic [DIV_W-1:0]      div_dividend;
   logic [REM_W-1:0]      div_divisor;
   logic                  div_done;
   logic [DIV_W-1:0]      div_quo;
   logic [REM_W-1:0]      div_rem;
   cal_ctl_type           cal_ctl;
   logic [13:0]           cal_year;
   logic [3:0]            cal_month;
   logic [4:0]            cal_day;

   assign in_secs   = req_tdata[30:0];
   assign in_hour   = req_tdata[35:31];
   assign in_minute = req_tdata[41:36];
   assign in_second = req_tdata[47:42];
   assign in_year   = req_tdata[61:48];
   assign in_month  = req_tdata[65:62];
   assign in_day    = req_tdata[70:66];
   assign in_func   = req_tuser[1:0];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // Sequencer: time and date loads; for an add, carry chain through the shared divider, then day stepping
   always_comb begin
      state_in     = state_ff;
      sec_in       = sec_ff;
      min_in       = min_ff;
      hour_in      = hour_ff;
      days_in      = days_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = SECS_PER_MIN;
      cal_ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (in_func)
                  FUNC_ADD: begin
                     div_start    = 1'b1;
                     div_dividend = {26'd0, sec_ff} + {1'b0, in_secs};
                     div_divisor  = SECS_PER_MIN;
                     state_in     = S_SEC;
                  end
                  FUNC_TIME: begin
                     hour_in  = in_hour;
                     min_in   = in_minute;
                     sec_in   = in_second;
                     state_in = S_OUT;
                  end
                  FUNC_DATE: begin
                     cal_ctl.load = 1'b1;
                     div_start    = 1'b1;
                     div_dividend = {18'd0, in_year};
                     div_divisor  = YEARS_PER_CENT;
                     state_in     = S_YEAR;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_SEC: begin
            if (div_done) begin
               sec_in       = div_rem[5:0];
               div_start    = 1'b1;
               div_dividend = {26'd0, min_ff} + div_quo;
               div_divisor  = SECS_PER_MIN;
               state_in     = S_MIN;
            end
         end
         S_MIN: begin
            if (div_done) begin
               min_in       = div_rem[5:0];
               div_start    = 1'b1;
               div_dividend = {27'd0, hour_ff} + div_quo;
               div_divisor  = HOURS_PER_DAY;
               state_in     = S_HOUR;
            end
         end
         S_HOUR: begin
            if (div_done) begin
               hour_in  = div_rem[4:0];
               days_in  = div_quo[14:0];
               state_in = S_DAYS;
            end
         end
         S_DAYS: begin
            if (days_ff == 15'd0) begin
               state_in = S_OUT;
            end else begin
               cal_ctl.step = 1'b1;
               days_in      = days_ff - 15'd1;
            end
         end
         S_YEAR: begin
            if (div_done) begin
               cal_ctl.set_leap = 1'b1;
               state_in         = S_OUT;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == S_OUT) && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {sec_ff, min_ff, hour_ff, cal_day, cal_month, cal_year};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sec_ff       <= 6'd0;
         min_ff       <= 6'd0;
         hour_ff      <= 5'd0;
         days_ff      <= 15'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sec_ff       <= sec_in;
         min_ff       <= min_in;
         hour_ff      <= hour_in;
         days_ff      <= days_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   ccsa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   ccsa_cal u_cal (
      .clock      (clock),
      .reset      (reset),
      .ctl        (cal_ctl),
      .load_year  (in_year),
      .load_month (in_month),
      .load_day   (in_day),
      .cent_rem   (div_rem),
      .cent_quo   (div_quo[1:0]),
      .year       (cal_year),
      .month      (cal_month),
      .day        (cal_day)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Divider completes only while the sequencer waits on it
   `CCSA_ASSERT_NOW(a_div_done_waited, clock, reset, div_done,
      (state_ff == S_SEC) || (state_ff == S_MIN) || (state_ff == S_HOUR) || (state_ff == S_YEAR),
      "divider done outside a carry pass")
   // Pending days exist only during day stepping
   `CCSA_ASSERT_NOW(a_days_in_step, clock, reset, days_ff != 15'd0,
      state_ff == S_DAYS, "days pending outside day stepping")
   // After an add the time of day is normalized
   `CCSA_ASSERT_NOW(a_time_normal, clock, reset,
      (state_ff == S_OUT) && ($past(state_ff) == S_DAYS),
      (sec_ff < 6'd60) && (min_ff < 6'd60) && (hour_ff < 5'd24),
      "time not normalized after add")
   // Posting a result returns the sequencer to idle
   `CCSA_ASSERT_NEXT(a_out_to_idle, clock, reset, (state_ff == S_OUT) && slot_free,
      (state_ff == S_IDLE) && rsp_tvalid, "result not posted")

endmodule

`default_nettype wire

>>> src/ccsa_div.sv
// Shared divider by a small constant: reciprocal multiply, then quotient and remainder.
`default_nettype none

module ccsa_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ccsa_pkg::DIV_W-1:0]     dividend,
   input  logic [ccsa_pkg::REM_W-1:0]     divisor,
   output logic                           done,
   output logic [ccsa_pkg::DIV_W-1:0]     quotient,
   output logic [ccsa_pkg::REM_W-1:0]     remainder
);
   import ccsa_pkg::*;

   logic                busy_mul_ff, busy_mul_in;  // operands held, product next
   logic                busy_fin_ff, busy_fin_in;  // product held, result next
   logic                done_ff, done_in;
   logic                long_ff, long_in;          // shift by SHIFT_LONG, else SHIFT_SHORT
   logic [DIV_W-1:0]    dvd_ff, dvd_in;
   logic [DIV_W-1:0]    recip_ff, recip_in;
   logic [REM_W-1:0]    dvs_ff, dvs_in;
   logic [2*DIV_W-1:0]  prod_ff, prod_in;
   logic [DIV_W-1:0]    quo_ff, quo_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    prod_quo;
   logic [2*REM_W-1:0]  back;

   // Quotient from the scaled product; the remainder is below 128, so low bits suffice
   assign prod_quo = long_ff ? DIV_W'(prod_ff >> SHIFT_LONG) : DIV_W'(prod_ff >> SHIFT_SHORT);
   assign back     = {{REM_W{1'b0}}, prod_quo[REM_W-1:0]} * {{REM_W{1'b0}}, dvs_ff};

   // Pass setup, product stage, result stage
   always_comb begin
      busy_mul_in = 1'b0;
      busy_fin_in = busy_mul_ff;
      done_in     = 1'b0;
      long_in     = long_ff;
      dvd_in      = dvd_ff;
      recip_in    = recip_ff;
      dvs_in      = dvs_ff;
      prod_in     = prod_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      if (busy_mul_ff) begin
         // upper operand halves are zero: a 32 x 32 product
         prod_in = (2*DIV_W)'(dvd_ff) * (2*DIV_W)'(recip_ff);
      end
      if (busy_fin_ff) begin
         quo_in  = prod_quo;
         rem_in  = dvd_ff[REM_W-1:0] - back[REM_W-1:0];
         done_in = 1'b1;
      end
      if (start) begin
         if (dividend < {{(DIV_W-REM_W){1'b0}}, divisor}) begin
            // nothing to carry: quotient zero, dividend is the remainder
            quo_in  = '0;
            rem_in  = dividend[REM_W-1:0];
            done_in = 1'b1;
         end else begin
            dvd_in      = dividend;
            dvs_in      = divisor;
            busy_mul_in = 1'b1;
            case (divisor)
               HOURS_PER_DAY: begin
                  recip_in = RECIP_HOUR;
                  long_in  = 1'b0;
               end
               YEARS_PER_CENT: begin
                  recip_in = RECIP_CENT;
                  long_in  = 1'b1;
               end
               default: begin
                  recip_in = RECIP_MIN;
                  long_in  = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_mul_ff <= 1'b0;
         busy_fin_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         busy_mul_ff <= busy_mul_in;
         busy_fin_ff <= busy_fin_in;
         done_ff     <= done_in;
      end
      long_ff  <= long_in;
      dvd_ff   <= dvd_in;
      recip_ff <= recip_in;
      dvs_ff   <= dvs_in;
      prod_ff  <= prod_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

>>> src/ccsa_cal.sv
// Date registers with Gregorian day stepping and incremental leap tracking.
`default_nettype none

module ccsa_cal (
   input  logic                  clock,
   input  logic                  reset,
   input  ccsa_pkg::cal_ctl_type ctl,
   input  logic [13:0]           load_year,
   input  logic [3:0]            load_month,
   input  logic [4:0]            load_day,
   input  logic [6:0]            cent_rem,
   input  logic [1:0]            cent_quo,
   output logic [13:0]           year,
   output logic [3:0]            month,
   output logic [4:0]            day
);
   import ccsa_pkg::*;

   logic [13:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [6:0]  yrem_ff, yrem_in;    // year mod 100
   logic [1:0]  ycent_ff, ycent_in;  // (year / 100) mod 4
   logic        leap;
   logic [4:0]  mlen;
   logic [5:0]  day_next;

   // Month length; months outside 1..12 run 31 days
   function automatic logic [4:0] month_days(input logic [3:0] m, input logic lp);
      logic [4:0] len;
      case (m)
         4'd2:                      len = lp ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

   // Leap: div by 4 and not by 100, or div by 400
   assign leap     = (yrem_ff == 7'd0) ? (ycent_ff == 2'd0) : (yrem_ff[1:0] == 2'd0);
   assign mlen     = month_days(month_ff, leap);
   assign day_next = {1'b0, day_ff} + 6'd1;

   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      yrem_in  = yrem_ff;
      ycent_in = ycent_ff;
      if (ctl.load) begin
         year_in  = load_year;
         month_in = load_month;
         day_in   = load_day;
      end else if (ctl.set_leap) begin
         yrem_in  = cent_rem;
         ycent_in = cent_quo;
      end else if (ctl.step) begin
         if (day_next > {1'b0, mlen}) begin
            day_in = 5'd1;
            if (month_ff >= MONTHS_PER_YEAR) begin
               month_in = 4'd1;
               if (year_ff >= LAST_YEAR) begin
                  // wrap to year 1
                  year_in  = 14'd1;
                  yrem_in  = 7'd1;
                  ycent_in = 2'd0;
               end else begin
                  year_in = year_ff + 14'd1;
                  if (yrem_ff == LAST_YEAR_REM) begin
                     yrem_in  = 7'd0;
                     ycent_in = ycent_ff + 2'd1;
                  end else begin
                     yrem_in = yrem_ff + 7'd1;
                  end
               end
            end else begin
               month_in = month_ff + 4'd1;
            end
         end else begin
            day_in = day_next[4:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff  <= 14'd1;
         month_ff <= 4'd1;
         day_ff   <= 5'd1;
         yrem_ff  <= 7'd1;
         ycent_ff <= 2'd0;
      end else begin
         year_ff  <= year_in;
         month_ff <= month_in;
         day_ff   <= day_in;
         yrem_ff  <= yrem_in;
         ycent_ff <= ycent_in;
      end
   end

   assign year  = year_ff;
   assign month = month_ff;
   assign day   = day_ff;

endmodule

`default_nettype wire

>>> tb/calendar_clock_second_adder_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the calendar clock: watches both channels, predicts each date and time and checks them.

package calendar_tb_pkg;

   // Unused operation code: the clock is left as it is
   localparam logic [1:0] FUNC_IDLE = 2'd3;

   // Request payload, first field in the top bits
   typedef struct packed {
      logic        pad;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [30:0] seconds;
   } req_item_type;

   // Response payload, first field in the top bits
   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
   } rsp_item_type;

endpackage

module calendar_clock_second_adder_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [ccsa_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [ccsa_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [ccsa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                              mismatch_count,
   output int                              outstanding
);

   import ccsa_pkg::*;
   import calendar_tb_pkg::*;

   localparam int MINS_PER_HOUR = 60;
   localparam int LEAP_CYCLE    = 4;
   localparam int LEAP_ERA      = 400;
   localparam int LEAP_FEB_DAYS = 29;
   localparam int FEB_DAYS      = 28;
   localparam int SHORT_MONTH   = 30;
   localparam int LONG_MONTH    = 31;
   localparam int PENDING_MASK  = 'h7FFF;   // day carry counter is 15 bits wide

   // Predicted clock state
   logic [13:0] cal_year;
   logic [3:0]  cal_month;
   logic [4:0]  cal_day;
   logic [4:0]  cal_hour;
   logic [5:0]  cal_minute;
   logic [5:0]  cal_second;

   rsp_item_type expected_dates[$];
   int           errors = 0;

   function automatic bit is_leap(input int y);
      return ((y % LEAP_CYCLE) == 0 && (y % YEARS_PER_CENT) != 0) || (y % LEAP_ERA) == 0;
   endfunction

   // Out-of-range months count as long months
   function automatic int month_length(input int y, input int m);
      if (m < 1 || m > MONTHS_PER_YEAR)
         return LONG_MONTH;
      case (m)
         2:          return is_leap(y) ? LEAP_FEB_DAYS : FEB_DAYS;
         4, 6, 9, 11: return SHORT_MONTH;
         default:    return LONG_MONTH;
      endcase
   endfunction

   function automatic void step_one_day();
      int next_day;
      next_day = cal_day + 1;
      if (next_day > month_length(cal_year, cal_month)) begin
         next_day = 1;
         if (cal_month >= MONTHS_PER_YEAR) begin
            cal_month = 4'd1;
            cal_year  = (cal_year >= LAST_YEAR) ? 14'd1 : cal_year + 14'd1;
         end else begin
            cal_month = cal_month + 4'd1;
         end
      end
      cal_day = 5'(next_day);
   endfunction

   // Apply one request to the predicted clock and return the date it should report
   function automatic rsp_item_type advance_calendar(input logic [1:0] op,
                                                     input req_item_type r);
      longint       sec_total;
      longint       min_total;
      longint       hr_total;
      int           days_left;
      rsp_item_type now;
      case (op)
         FUNC_ADD: begin
            sec_total  = longint'(cal_second) + longint'(r.seconds);
            min_total  = longint'(cal_minute) + sec_total / SECS_PER_MIN;
            cal_second = 6'(sec_total % SECS_PER_MIN);
            hr_total   = longint'(cal_hour) + min_total / MINS_PER_HOUR;
            cal_minute = 6'(min_total % MINS_PER_HOUR);
            days_left  = int'(hr_total / HOURS_PER_DAY) & PENDING_MASK;
            cal_hour   = 5'(hr_total % HOURS_PER_DAY);
            repeat (days_left) step_one_day();
         end
         FUNC_TIME: begin
            cal_hour   = r.hour;
            cal_minute = r.minute;
            cal_second = r.second;
         end
         FUNC_DATE: begin
            cal_year  = r.year;
            cal_month = r.month;
            cal_day   = r.day;
         end
         default: ;
      endcase
      now.year   = cal_year;
      now.month  = cal_month;
      now.day    = cal_day;
      now.hour   = cal_hour;
      now.minute = cal_minute;
      now.second = cal_second;
      return now;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   // Response is checked before the request of the same edge is queued
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         cal_year   = 14'd1;
         cal_month  = 4'd1;
         cal_day    = 5'd1;
         cal_hour   = '0;
         cal_minute = '0;
         cal_second = '0;
         expected_dates.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_item_type'(rsp_tdata);
            if (expected_dates.size() == 0) begin
               report_mismatch("response without a request, data", longint'(rsp_tdata), 0);
            end else begin
               want = expected_dates.pop_front();
               if (got.year != want.year)     report_mismatch("year", got.year, want.year);
               if (got.month != want.month)   report_mismatch("month", got.month, want.month);
               if (got.day != want.day)       report_mismatch("day", got.day, want.day);
               if (got.hour != want.hour)     report_mismatch("hour", got.hour, want.hour);
               if (got.minute != want.minute) report_mismatch("minute", got.minute, want.minute);
               if (got.second != want.second) report_mismatch("second", got.second, want.second);
            end
         end
         if (req_tvalid && req_tready)
            expected_dates.push_back(advance_calendar(req_tuser, req_item_type'(req_tdata)));
      end
      mismatch_count <= errors;
      outstanding    <= expected_dates.size();
   end

endmodule

>>> tb/calendar_clock_second_adder_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the calendar clock: drives requests and response stalls, gives the verdict.

module calendar_clock_second_adder_top_tb;

   import ccsa_pkg::*;
   import calendar_tb_pkg::*;

   localparam int          RANDOM_REQUESTS = 750;
   localparam int          MAX_HUGE_ADDS   = 6;
   localparam int          DRAIN_CYCLES    = 64;
   localparam int          HOLD_AT         = 200;   // response count where the long stall starts
   localparam int          HOLD_CYCLES     = 400;
   localparam int          SECS_PER_DAY    = 86400;
   localparam logic [30:0] MAX_SECONDS     = 31'h7FFF_FFFF;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = FUNC_ADD;
   logic                  rsp_tready = 1'b0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int mismatch_count;
   int outstanding;
   int huge_adds = 0;
   int send_calm = 0;
   int recv_calm = 0;

   calendar_clock_second_adder_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   calendar_clock_second_adder_checker date_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always #5 clock = ~clock;

   // Idle cycles before the next transfer; occasional calm stretches with none
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0)
         calm = $urandom_range(8, 40);
      return $urandom_range(0, 15);
   endfunction

   // Random bits in every field but pad; the ones an operation uses are overwritten
   function automatic req_item_type noise_fields();
      logic [95:0]  bits;
      req_item_type r;
      bits  = {$urandom, $urandom, $urandom};
      r     = bits[REQ_DATA_W-1:0];
      r.pad = 1'b0;
      return r;
   endfunction

   task automatic send_request(input logic [1:0] op, input req_item_type fields);
      int gap;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= fields;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic add_seconds(input logic [30:0] s);
      req_item_type f;
      f         = noise_fields();
      f.seconds = s;
      send_request(FUNC_ADD, f);
   endtask

   task automatic load_time(input logic [4:0] h, input logic [5:0] m, input logic [5:0] s);
      req_item_type f;
      f        = noise_fields();
      f.hour   = h;
      f.minute = m;
      f.second = s;
      send_request(FUNC_TIME, f);
   endtask

   task automatic load_date(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d);
      req_item_type f;
      f       = noise_fields();
      f.year  = y;
      f.month = m;
      f.day   = d;
      send_request(FUNC_DATE, f);
   endtask

   // Mostly short ticks; a capped few jumps of many thousand days
   task automatic random_add();
      int          pick;
      logic [30:0] s;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         s = 31'($urandom_range(0, 3600));
      else if (pick < 75)
         s = 31'($urandom_range(0, 2 * SECS_PER_DAY));
      else if (pick < 95)
         s = 31'($urandom_range(0, 60 * SECS_PER_DAY));
      else if (pick < 99 || huge_adds >= MAX_HUGE_ADDS)
         s = 31'($urandom_range(0, 24'hFF_FFFF));
      else begin
         s = 31'($urandom);
         huge_adds++;
      end
      add_seconds(s);
   endtask

   // Times near the end of the day, sometimes raw field values
   task automatic random_time();
      req_item_type f;
      f = noise_fields();
      if ($urandom_range(0, 9) != 0) begin
         f.hour   = $urandom_range(0, 1) ? 5'd23 : 5'($urandom_range(0, 23));
         f.minute = $urandom_range(0, 1) ? 6'd59 : 6'($urandom_range(0, 59));
         f.second = $urandom_range(0, 1) ? 6'd59 : 6'($urandom_range(0, 59));
      end
      send_request(FUNC_TIME, f);
   endtask

   // Dates near month ends and century years, sometimes raw field values
   task automatic random_date();
      req_item_type f;
      f = noise_fields();
      if ($urandom_range(0, 9) != 0) begin
         case ($urandom_range(0, 4))
            0:       f.year = 14'd9999;
            1:       f.year = 14'd2000;
            2:       f.year = 14'd1900;
            3:       f.year = 14'(4 * $urandom_range(1, 2499));
            default: f.year = 14'($urandom_range(1, 9999));
         endcase
         case ($urandom_range(0, 3))
            0:       f.month = 4'd2;
            1:       f.month = 4'd12;
            default: f.month = 4'($urandom_range(1, 12));
         endcase
         f.day = $urandom_range(0, 1) ? 5'($urandom_range(28, 31)) : 5'($urandom_range(1, 31));
      end
      send_request(FUNC_DATE, f);
   endtask

   // Stimulus and verdict
   initial begin
      int sent;
      int pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset state, unused code, day, year and leap rollovers, odd loads
      add_seconds(31'd0);
      send_request(FUNC_IDLE, noise_fields());
      load_time(5'd23, 6'd59, 6'd59);
      add_seconds(31'd1);
      load_date(14'd9999, 4'd12, 5'd31);
      load_time(5'd23, 6'd59, 6'd59);
      add_seconds(31'd1);
      load_date(14'd2024, 4'd2, 5'd28);
      add_seconds(31'(SECS_PER_DAY));
      add_seconds(31'(SECS_PER_DAY));
      load_date(14'd1900, 4'd2, 5'd28);
      add_seconds(31'(SECS_PER_DAY));
      load_date(14'd2000, 4'd2, 5'd28);
      add_seconds(31'(SECS_PER_DAY));
      load_time(5'd31, 6'd63, 6'd63);
      add_seconds(31'd0);
      load_date(14'h3FFF, 4'hF, 5'd31);
      add_seconds(31'(SECS_PER_DAY));
      load_date(14'd0, 4'd0, 5'd0);
      add_seconds(31'(31 * SECS_PER_DAY));
      load_date(14'd0, 4'd2, 5'd28);
      add_seconds(31'(SECS_PER_DAY));
      load_time(5'd0, 6'd0, 6'd0);
      add_seconds(MAX_SECONDS);
      huge_adds++;
      send_request(FUNC_IDLE, noise_fields());

      // Random: single operations mixed with date, time, tick sequences
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            random_add();
            sent += 1;
         end else if (pick < 62) begin
            random_time();
            sent += 1;
         end else if (pick < 76) begin
            random_date();
            sent += 1;
         end else if (pick < 80) begin
            send_request(FUNC_IDLE, noise_fields());
            sent += 1;
         end else begin
            random_date();
            random_time();
            add_seconds(31'($urandom_range(0, 600)));
            sent += 3;
         end
      end
      req_tvalid <= 1'b0;

      // Drain: let the last push settle, then wait out the pending responses
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("calendar_clock_second_adder_top verification clean");
      else
         $display("calendar_clock_second_adder_top verification failed");
      $finish;
   end

   // Response side: random stalls, plus one long hold-off to back up the input
   initial begin
      int stall;
      int responses;
      responses = 0;
      while (reset) @(posedge clock);
      forever begin
         stall = (responses == HOLD_AT) ? HOLD_CYCLES : draw_gap(recv_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         responses++;
      end
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("calendar_clock_second_adder_top verification failed");
      $finish;
   end

endmodule
